@@ hw/rtl/scfc_pkg.sv @@
// Shared types, codes and CRC-8 byte update for the SPI sensor frame codec.
package scfc_pkg;

    localparam logic [7:0] CRC_POLY   = 8'h1D;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [1:0] RS_ERROR   = 2'd3;
    localparam int         IN_BYTES   = 7;
    localparam int         OUT_BYTES  = 7;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        FS_OK       = 2'd0,
        FS_CRC_ERR  = 2'd1,
        FS_DEV_ERR  = 2'd2,
        FS_RESERVED = 2'd3
    } t_fstat;

    typedef struct packed {
        t_cmd        cmd;
        logic [23:0] body;
        logic [7:0]  rx_crc;
        logic [23:0] work;
        logic [7:0]  crc;
    } t_item;

    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/scfc_crc_stage.sv @@
// One pipeline stage that folds the leading byte of the work word into the CRC.
module scfc_crc_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  scfc_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output scfc_pkg::t_item o_item
);

    logic            r_valid;
    scfc_pkg::t_item r_item;
    scfc_pkg::t_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item      = i_item;
        n_item.crc  = scfc_pkg::crc_byte(i_item.crc, i_item.work[23:16]);
        n_item.work = {i_item.work[15:0], 8'h00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

@@ hw/rtl/spi_sensor_frame_crc8_codec.sv @@
// Top level of the SPI sensor frame codec: request packing, CRC pipeline, response check.
//
//  channel   | direction | fields, lowest bit first
//  ----------+-----------+--------------------------------------------------------------
//  s_axis    | in        | tuser: cmd[1:0]
//            |           | tdata: reg_addr[4:0] write_data[20:5] rx_frame[52:21]
//  m_axis    | out       | tdata: tx_frame[31:0] frame_status[33:32] return_status[35:34]
//            |           |        read_value[51:36]
//
// One transaction per cycle sustained while m_axis is ready; data passes the input register,
// three CRC byte stages and the output register. Reset clears only the valid bits. A stall on
// m_axis holds every stage that is full; empty stages keep filling, so nothing is lost.
module spi_sensor_frame_crc8_codec (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [1:0]                        i_s_axis_tuser,  // cmd
    input  logic [8*scfc_pkg::IN_BYTES-1:0]   i_s_axis_tdata,  // reg_addr, write_data, rx_frame
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [8*scfc_pkg::OUT_BYTES-1:0]  o_m_axis_tdata   // tx_frame, frame_status,
                                                               // return_status, read_value
);

    logic [1:0]  in_cmd;
    logic [4:0]  in_addr;
    logic [15:0] in_wdata;
    logic [31:0] in_rx;

    assign in_cmd   = i_s_axis_tuser;
    assign in_addr  = i_s_axis_tdata[4:0];
    assign in_wdata = i_s_axis_tdata[20:5];
    assign in_rx    = i_s_axis_tdata[52:21];

    logic            r_in_valid;
    scfc_pkg::t_item r_in_item;
    scfc_pkg::t_item n_in_item;
    logic            in_ready;

    logic            s1_valid, s1_ready, s2_valid, s2_ready, s3_valid, s3_ready;
    scfc_pkg::t_item s1_item, s2_item, s3_item;

    logic            r_out_valid;
    logic [31:0]     r_tx;
    logic [1:0]      r_fstat;
    logic [1:0]      r_rs;
    logic [15:0]     r_rval;
    logic [31:0]     n_tx;
    logic [1:0]      n_fstat;
    logic [1:0]      n_rs;
    logic [15:0]     n_rval;
    logic            out_ready;
    logic [7:0]      crc_final;

    // Pack the request body or pick up the response body.
    always_comb begin
        n_in_item        = '0;
        n_in_item.cmd    = scfc_pkg::t_cmd'(in_cmd);
        n_in_item.rx_crc = in_rx[7:0];
        n_in_item.crc    = scfc_pkg::CRC_INIT;
        case (scfc_pkg::t_cmd'(in_cmd))
            scfc_pkg::CMD_READ:  n_in_item.body = {1'b0, in_addr, 2'b00, 16'h0000};
            scfc_pkg::CMD_WRITE: n_in_item.body = {1'b1, in_addr, 2'b00, in_wdata};
            scfc_pkg::CMD_CHECK: n_in_item.body = in_rx[31:8];
            default:             n_in_item.body = 24'h000000;
        endcase
        n_in_item.work = n_in_item.body;
    end

    assign in_ready        = !r_in_valid || s1_ready;
    assign o_s_axis_tready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_axis_tvalid) begin
            r_in_item <= n_in_item;
        end
    end

    scfc_crc_stage u_crc_b2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (s1_ready),
        .i_item  (r_in_item),
        .o_valid (s1_valid),
        .i_ready (s2_ready),
        .o_item  (s1_item)
    );

    scfc_crc_stage u_crc_b1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s2_ready),
        .i_item  (s1_item),
        .o_valid (s2_valid),
        .i_ready (s3_ready),
        .o_item  (s2_item)
    );

    scfc_crc_stage u_crc_b0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s3_ready),
        .i_item  (s2_item),
        .o_valid (s3_valid),
        .i_ready (out_ready),
        .o_item  (s3_item)
    );

    // Finish the CRC and form the result fields.
    assign crc_final = ~s3_item.crc;

    always_comb begin
        n_tx    = 32'h0;
        n_fstat = scfc_pkg::FS_OK;
        n_rs    = 2'b00;
        n_rval  = 16'h0000;
        case (s3_item.cmd)
            scfc_pkg::CMD_READ, scfc_pkg::CMD_WRITE: begin
                n_tx = {s3_item.body, crc_final};
            end
            scfc_pkg::CMD_CHECK: begin
                if (s3_item.rx_crc != crc_final) begin
                    n_fstat = scfc_pkg::FS_CRC_ERR;
                end else begin
                    n_rs    = s3_item.body[17:16];
                    n_rval  = s3_item.body[15:0];
                    n_fstat = (s3_item.body[17:16] == scfc_pkg::RS_ERROR) ?
                              scfc_pkg::FS_DEV_ERR : scfc_pkg::FS_OK;
                end
            end
            default: begin
                n_tx = 32'h0;
            end
        endcase
    end

    assign out_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && s3_valid) begin
            r_tx    <= n_tx;
            r_fstat <= n_fstat;
            r_rs    <= n_rs;
            r_rval  <= n_rval;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'h0, r_rval, r_rs, r_fstat, r_tx};

endmodule
